### rtl/pbd_pkg.sv
// Package for the PackBits run decoder: payload structs, queue entry, constants.
// No dependencies; every rtl file refers to it by scoped names.
`timescale 1ns / 1ps

package pbd_pkg;

   localparam int TOTAL_W   = 24;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
   // repeat count (up to 128) times bytes per value (up to 7)
   localparam int ADD_W     = 11;
   localparam int QPTR_W    = 1;
   localparam int QUEUE_DEPTH = 1 << QPTR_W;
   localparam int PADDR_W   = 3;
   localparam logic [7:0] HDR_NOOP = 8'd128;

   typedef struct packed {
      logic [7:0] packed_byte;
      logic       end_of_data;
   } req_type;

   typedef struct packed {
      logic [31:0]        value;
      logic [7:0]         repeat_count;
      logic [TOTAL_W-1:0] total_bytes;
      logic               truncated;
      logic               last;
   } rsp_type;

   // classified work handed from the parser to the output side
   typedef struct packed {
      logic [31:0]      value;
      logic [7:0]       repeat_count;
      logic [ADD_W-1:0] add_bytes;
      logic             truncated;
      logic             last;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

### rtl/pbd_front.sv
// Parser front end: takes packed bytes, tracks headers and value bytes, and
// pushes one queue entry per completed value or end byte. Uses pbd_pkg.
`timescale 1ns / 1ps

module pbd_front #(
   parameter int MAX_VALUE_BYTES = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [2:0]          bytes_per_value,
   input  logic                req_valid,
   input  pbd_pkg::req_type    req_data,
   input  pbd_pkg::qstat_type  qstat,
   output logic                req_stall,
   output logic                push,
   output pbd_pkg::entry_type  push_data
);

   localparam int VS_W  = $clog2(MAX_VALUE_BYTES + 1);
   localparam int ACC_W = 8 * MAX_VALUE_BYTES;

   typedef enum logic [2:0] {
      MODE_HEADER  = 3'b001,
      MODE_LITERAL = 3'b010,
      MODE_REPEAT  = 3'b100
   } mode_type;

   mode_type         mode_ff, mode_in;
   logic [7:0]       left_ff, left_in;
   logic [VS_W-1:0]  idx_ff, idx_in;
   logic [ACC_W-1:0] acc_ff, acc_in;

   logic [VS_W-1:0]  vs;
   logic [VS_W-1:0]  idx_next;
   logic [ACC_W-1:0] acc_shift;
   logic             accept;
   logic             done;
   logic [7:0]       rep;
   logic [31:0]      val;

   assign req_stall = qstat.full;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      if (bytes_per_value == 3'd0) begin
         vs = VS_W'(1);
      end else if (32'(bytes_per_value) > 32'(MAX_VALUE_BYTES)) begin
         vs = VS_W'(MAX_VALUE_BYTES);
      end else begin
         vs = VS_W'(bytes_per_value);
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      left_in   = left_ff;
      idx_in    = idx_ff;
      acc_in    = acc_ff;
      done      = 1'b0;
      rep       = 8'd0;
      val       = 32'd0;
      idx_next  = idx_ff + VS_W'(1);
      acc_shift = ACC_W'({acc_ff, req_data.packed_byte});
      unique case (mode_ff)
         MODE_HEADER: begin
            if (req_data.packed_byte < pbd_pkg::HDR_NOOP) begin
               mode_in = MODE_LITERAL;
               left_in = req_data.packed_byte + 8'd1;
            end else if (req_data.packed_byte > pbd_pkg::HDR_NOOP) begin
               mode_in = MODE_REPEAT;
               left_in = 8'(9'd257 - {1'b0, req_data.packed_byte});
            end
            idx_in = '0;
            acc_in = '0;
         end
         MODE_LITERAL, MODE_REPEAT: begin
            acc_in = acc_shift;
            idx_in = idx_next;
            if (idx_next >= vs) begin
               done   = 1'b1;
               val    = 32'(acc_shift);
               idx_in = '0;
               acc_in = '0;
               if (mode_ff == MODE_LITERAL) begin
                  rep     = 8'd1;
                  left_in = left_ff - 8'd1;
                  if (left_ff == 8'd1) begin
                     mode_in = MODE_HEADER;
                  end
               end else begin
                  rep     = left_ff;
                  left_in = 8'd0;
                  mode_in = MODE_HEADER;
               end
            end
         end
         default: begin
            mode_in = MODE_HEADER;
         end
      endcase

      push_data.value        = val;
      push_data.repeat_count = rep;
      push_data.add_bytes    = pbd_pkg::ADD_W'(rep) * pbd_pkg::ADD_W'(vs);
      push_data.truncated    = req_data.end_of_data & (mode_in != MODE_HEADER);
      push_data.last         = req_data.end_of_data;

      // end of row drops any partial packet
      if (req_data.end_of_data) begin
         mode_in = MODE_HEADER;
         left_in = 8'd0;
         idx_in  = '0;
         acc_in  = '0;
      end
   end

   assign push = accept & (done | req_data.end_of_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_HEADER;
         left_ff <= 8'd0;
         idx_ff  <= '0;
         acc_ff  <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         left_ff <= left_in;
         idx_ff  <= idx_in;
         acc_ff  <= acc_in;
      end
   end

endmodule

### rtl/pbd_queue.sv
// Two-entry queue between the parser and the output stage.
// Uses pbd_pkg for the entry type and depth.
`timescale 1ns / 1ps

module pbd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pbd_pkg::entry_type  push_data,
   input  logic                pop,
   output pbd_pkg::entry_type  pop_data,
   output pbd_pkg::qstat_type  qstat
);

   pbd_pkg::entry_type mem_ff [pbd_pkg::QUEUE_DEPTH];

   logic [pbd_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [pbd_pkg::QPTR_W:0]   count_ff;

   assign qstat.full  = (count_ff == (pbd_pkg::QPTR_W + 1)'(pbd_pkg::QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign pop_data    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + pbd_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + pbd_pkg::QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (pbd_pkg::QPTR_W + 1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (pbd_pkg::QPTR_W + 1)'(1);
         end
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (pbd_pkg::QPTR_W + 1)'(pbd_pkg::QUEUE_DEPTH))
      else $error("queue count above depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      qstat.full |-> !push)
      else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      qstat.empty |-> !pop)
      else $error("pop from empty queue");
`endif

endmodule

### rtl/pbd_back.sv
// Output stage: running byte total with saturation and the response register.
// Uses pbd_pkg for the entry and response types.
`timescale 1ns / 1ps

module pbd_back (
   input  logic                clock,
   input  logic                reset,
   input  pbd_pkg::qstat_type  qstat,
   input  pbd_pkg::entry_type  pop_data,
   output logic                pop,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output pbd_pkg::rsp_type    rsp_data
);

   logic [pbd_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic [pbd_pkg::TOTAL_W:0]   sum;
   logic [pbd_pkg::TOTAL_W-1:0] total_out;
   logic                        rsp_valid_ff;
   pbd_pkg::rsp_type            rsp_data_ff;
   logic                        load;

   assign load = ~rsp_valid_ff | ~rsp_stall;
   assign pop  = load & ~qstat.empty;

   always_comb begin
      sum = (pbd_pkg::TOTAL_W + 1)'(total_ff) + (pbd_pkg::TOTAL_W + 1)'(pop_data.add_bytes);
      if (sum > (pbd_pkg::TOTAL_W + 1)'(pbd_pkg::TOTAL_MAX)) begin
         total_out = pbd_pkg::TOTAL_MAX;
      end else begin
         total_out = sum[pbd_pkg::TOTAL_W-1:0];
      end
      total_in = pop_data.last ? '0 : total_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            total_ff <= total_in;
         end
         if (load) begin
            rsp_valid_ff <= ~qstat.empty;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff.value        <= pop_data.value;
         rsp_data_ff.repeat_count <= pop_data.repeat_count;
         rsp_data_ff.total_bytes  <= total_out;
         rsp_data_ff.truncated    <= pop_data.truncated;
         rsp_data_ff.last         <= pop_data.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_total_cleared: assert property (@(posedge clock) disable iff (reset)
      (pop && pop_data.last) |=> (total_ff == '0))
      else $error("byte total not cleared after end of row");
`endif

endmodule

### rtl/packbits_run_decoder.sv
// Top level of the PackBits run decoder: register port, parser, queue, output.
// Depends on pbd_pkg, pbd_front, pbd_queue and pbd_back.
//
// Usage:
//   req_* carries one packed byte per request with an end-of-row flag; a
//   request is taken when req_valid is high and req_stall is low.
//   rsp_* carries decoded values with their repeat count, the running byte
//   total and, on the end-of-row result, last and truncated.
//   bytes_per_value (register 0, byte address 0) sets bytes per value; write it
//   only while no row is in flight.
// Timing:
//   One request per cycle sustained while req_stall is low. The result of the
//   request that completes it is registered in the queue, then in the response
//   register. Requests that complete nothing produce no result.
//   req_stall rises only when the two-entry queue is full, i.e. when rsp_stall
//   has held the response register and backed work up behind it.
// Reset:
//   Synchronous. Parsing starts at a header, the byte total is zero and
//   bytes_per_value returns to 1.
`timescale 1ns / 1ps

module packbits_run_decoder #(
   parameter int MAX_VALUE_BYTES = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  pbd_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output pbd_pkg::rsp_type            rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [pbd_pkg::PADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   logic [2:0]          bytes_per_value_ff;
   logic                push, pop;
   pbd_pkg::entry_type  push_data, pop_data;
   pbd_pkg::qstat_type  qstat;
   logic                reg_hit;

   // only register 0 exists; bit 2 selects the next word
   assign reg_hit = ~paddr[2];
   assign pready  = 1'b1;
   assign prdata  = reg_hit ? {29'd0, bytes_per_value_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_per_value_ff <= 3'd1;
      end else if (psel && penable && pwrite && pready && reg_hit) begin
         bytes_per_value_ff <= pwdata[2:0];
      end
   end

   pbd_front #(
      .MAX_VALUE_BYTES(MAX_VALUE_BYTES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .bytes_per_value (bytes_per_value_ff),
      .req_valid       (req_valid),
      .req_data        (req_data),
      .qstat           (qstat),
      .req_stall       (req_stall),
      .push            (push),
      .push_data       (push_data)
   );

   pbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .qstat     (qstat)
   );

   pbd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .qstat     (qstat),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
